>>> hdl/lirs_pkg.sv
`timescale 1ns / 1ps

package lirs_pkg;

  // fixed-point format of position and step
  localparam int FRAC_BITS   = 20;
  localparam int MAX_OUTPUTS = 8;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = FRAC_BITS + 4;
  localparam int POS_W    = FRAC_BITS + 5;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int FRAC_W   = FRAC_BITS + 1;
  localparam int PROD_W   = DIFF_W + FRAC_W + 1;
  localparam int ACC_W    = PROD_W + 1;
  localparam int CNT_W    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

  localparam logic [POS_W-1:0]  ONE_POS    = POS_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(3) << FRAC_BITS;

  // controller state, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_RND  = 3'b100
  } lirs_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming sample as current
    logic skip;     // item with no results: retire it at once
    logic mul;      // form (cur - prev) * position
    logic emit;     // round, load result register, advance position
    logic last;     // emitted result closes the item
  } lirs_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic pos_pending;  // position not past the current sample
    logic next_over;    // position after one more step is past it
    logic out_free;     // result register can take a new value
  } lirs_sts_t;

endpackage

>>> hdl/lirs_ctrl.sv
`timescale 1ns / 1ps

module lirs_ctrl import lirs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lirs_sts_t sts,
  output lirs_cmd_t cmd
);

  lirs_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_r, last_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    last_nxt    = last_r;
    cmd         = '0;
    cmd.last    = last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.pos_pending) begin
            cmd.capture = 1'b1;
            cnt_nxt     = '0;
            state_nxt   = ST_MUL;
          end else begin
            cmd.skip = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        last_nxt  = (cnt_r == CNT_W'(MAX_OUTPUTS - 1)) || sts.next_over;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r + CNT_W'(1);
            state_nxt = ST_MUL;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

>>> hdl/lirs_dp.sv
`timescale 1ns / 1ps

module lirs_dp import lirs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       cfg_wr_en,
  input  logic        [STEP_W-1:0]   cfg_wr_data,
  input  lirs_cmd_t                  cmd,
  output lirs_sts_t                  sts,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_last
);

  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32767);

  logic        [STEP_W-1:0]   step_r;
  logic        [POS_W-1:0]    pos_r;
  logic signed [SAMPLE_W-1:0] prev_r;
  logic signed [SAMPLE_W-1:0] cur_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_last_r;

  logic        [POS_W-1:0]    pos_adv;
  logic        [POS_W-1:0]    pos_adv_fin;
  logic        [POS_W-1:0]    pos_fin;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [FRAC_W:0]     frac_s;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [ACC_W-1:0]    quo;
  logic signed [SAMPLE_W-1:0] sat;

  // position stepping and end-of-item move back by one period, clamped at zero
  assign pos_adv     = pos_r + POS_W'(step_r);
  assign pos_adv_fin = (pos_adv >= ONE_POS) ? (pos_adv - ONE_POS) : '0;
  assign pos_fin     = (pos_r >= ONE_POS) ? (pos_r - ONE_POS) : '0;

  assign sts.pos_pending = (pos_r <= ONE_POS);
  assign sts.next_over   = (pos_adv > ONE_POS);
  assign sts.out_free    = !out_valid_r || !out_stall;

  // multiplier operands, position is at most one here
  assign diff   = DIFF_W'(cur_r) - DIFF_W'(prev_r);
  assign frac_s = $signed({1'b0, pos_r[FRAC_W-1:0]});

  // round half away from zero, then saturate
  assign acc = (ACC_W'(prev_r) <<< FRAC_BITS) + ACC_W'(prod_r);
  assign rnd = acc + HALF - ACC_W'(acc < 0);
  assign quo = rnd >>> FRAC_BITS;
  always_comb begin
    if (quo > SAT_MAX) begin
      sat = SAMPLE_W'(SAT_MAX);
    end else if (quo < SAT_MIN) begin
      sat = SAMPLE_W'(SAT_MIN);
    end else begin
      sat = quo[SAMPLE_W-1:0];
    end
  end

  // step, position and previous sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
      pos_r  <= ONE_POS;
      prev_r <= '0;
    end else if (cfg_wr_en) begin
      step_r <= cfg_wr_data;
      pos_r  <= ONE_POS;
      prev_r <= '0;
    end else if (cmd.skip) begin
      pos_r  <= pos_fin;
      prev_r <= in_sample;
    end else if (cmd.emit) begin
      if (cmd.last) begin
        pos_r  <= pos_adv_fin;
        prev_r <= cur_r;
      end else begin
        pos_r <= pos_adv;
      end
    end
  end

  // current sample and product
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_r <= in_sample;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(diff) * PROD_W'(frac_s);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample_r <= sat;
      out_last_r   <= cmd.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

endmodule

>>> hdl/linear_interp_resampler_core.sv
`timescale 1ns / 1ps
// an item's sample is captured when it is taken; each of its results is formed by a
//   multiply state (product registered), then a round state that saturates it into the
//   result register once that register is free; the input stays stalled until the last
//   result of the item is loaded, and an item with no result is retired at once
// reset (rst_n low, synchronous): step 3.0, position 1.0, previous sample 0, idle
// a write to cfg_wr_data restores position and previous sample to the same values

module linear_interp_resampler_core import lirs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_last,
  input  logic                       cfg_wr_en,
  input  logic        [STEP_W-1:0]   cfg_wr_data
);

  lirs_cmd_t cmd;
  lirs_sts_t sts;

  // sequencing of results per item
  lirs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // interpolation arithmetic and state
  lirs_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_sample   (in_sample),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sample  (out_sample),
    .out_last    (out_last)
  );

endmodule

>>> tb/resample_checker.sv
`timescale 1ns / 1ps

module resample_checker import lirs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] out_sample,
  input  logic                       out_last,
  input  logic                       cfg_wr_en,
  input  logic        [STEP_W-1:0]   cfg_wr_data,
  output int                         exp_count,
  output int                         fail_count
);

  localparam int REPORT_MAX = 10;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } out_item_t;

  // predicted block state
  logic        [STEP_W-1:0]   step_q;
  logic        [POS_W-1:0]    pos_q;
  logic signed [SAMPLE_W-1:0] prev_q;

  out_item_t pending_outputs[$];
  int        mismatches;
  int        out_seen;

  initial begin
    exp_count  = 0;
    fail_count = 0;
    mismatches = 0;
    out_seen   = 0;
  end

  // prev + (cur - prev) * frac, rounded half away from zero, clipped to +-32767
  function automatic logic signed [SAMPLE_W-1:0] lerp_round(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic        [POS_W-1:0]    frac
  );
    longint acc;
    longint half;
    longint r;
    half = longint'(1) <<< (FRAC_BITS - 1);
    acc  = longint'(a) * (longint'(1) <<< FRAC_BITS)
         + (longint'(b) - longint'(a)) * longint'(frac);
    if (acc >= 0) begin
      r = (acc + half) >>> FRAC_BITS;
    end else begin
      r = -((-acc + half) >>> FRAC_BITS);
    end
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return r[SAMPLE_W-1:0];
  endfunction

  // output points that fall up to the current sample, at most MAX_OUTPUTS of them
  task automatic resample_item(input logic signed [SAMPLE_W-1:0] cur);
    int        n;
    out_item_t item;
    n = 0;
    while (n < MAX_OUTPUTS && pos_q <= ONE_POS) begin
      item.sample = lerp_round(prev_q, cur, pos_q);
      item.last   = 1'b0;
      pending_outputs.insert(pending_outputs.size(), item);
      n++;
      pos_q = pos_q + POS_W'(step_q);
    end
    if (n > 0) pending_outputs[pending_outputs.size() - 1].last = 1'b1;
    // move back one source period, clamp at zero
    if (pos_q >= ONE_POS) begin
      pos_q = pos_q - ONE_POS;
    end else begin
      pos_q = '0;
    end
    prev_q = cur;
  endtask

  task automatic note_mismatch();
    mismatches++;
  endtask

  // watch both channels and the step register
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      step_q = STEP_RESET;
      pos_q  = ONE_POS;
      prev_q = '0;
      pending_outputs.delete();
    end else begin
      // compare an accepted result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_outputs.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: unexpected result sample %0d last %0b",
                     $realtime, out_sample, out_last);
          note_mismatch();
        end else begin
          want = pending_outputs.pop_front();
          if (out_sample !== want.sample || out_last !== want.last) begin
            if (mismatches < REPORT_MAX)
              $display("%0t: result %0d expected sample %0d last %0b, got sample %0d last %0b",
                       $realtime, out_seen, want.sample, want.last, out_sample, out_last);
            note_mismatch();
          end
        end
        out_seen++;
      end
      // step write restores position to 1.0 and clears previous sample
      if (cfg_wr_en) begin
        step_q = cfg_wr_data;
        pos_q  = ONE_POS;
        prev_q = '0;
      end
      if (in_valid && !in_stall) resample_item(in_sample);
    end
    exp_count  <= pending_outputs.size();
    fail_count <= mismatches;
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lirs_pkg::*;

  localparam int    RANDOM_ITEMS   = 130;
  localparam int    IDLE_PCT       = 7;
  localparam int    HOLD_CYCLES    = 80;
  localparam int    WATCHDOG_LIMIT = 2000;
  localparam int    SETTLE_CYCLES  = 8;
  localparam int    END_CYCLES     = 20;
  localparam logic [STEP_W-1:0] STEP_ONE  = STEP_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_HALF = STEP_W'(1) << (FRAC_BITS - 1);
  localparam logic [STEP_W-1:0] STEP_MIN  = STEP_W'(1) << (FRAC_BITS - 3);
  localparam logic [STEP_W-1:0] STEP_MAX  = '1;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_last;
  logic                       cfg_wr_en = 1'b0;
  logic        [STEP_W-1:0]   cfg_wr_data = '0;

  int exp_count;
  int fail_count;

  // idling controls for sender and receiver
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int hold_req   = 0;
  int hold_taken = 0;
  int hold_left  = 0;
  int idle_cycles = 0;

  linear_interp_resampler_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sample  (out_sample),
    .out_last    (out_last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  resample_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sample  (out_sample),
    .out_last    (out_last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .exp_count   (exp_count),
    .fail_count  (fail_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_taken) begin
      hold_taken = hold_req;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= rx_idle_en && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // no accepted item, result or step write for too long ends the run as a mismatch
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("linear_interp_resampler_core: mismatch");
        $finish;
      end
    end
  end

  // offer one sample and hold it until taken
  task automatic send_item(input logic signed [SAMPLE_W-1:0] s);
    if (tx_idle_en && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait for every predicted result, plus settle time
  task automatic drain(input int pad);
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_count != 0) @(posedge clk);
    repeat (pad) @(posedge clk);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] v);
    drain(SETTLE_CYCLES);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int                         sent;
    int                         phase;
    int                         phase_len;
    int                         sel;
    logic        [STEP_W-1:0]   step_v;
    logic signed [SAMPLE_W-1:0] s;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset step 3.0, first point exactly on the sample
    send_item(16'sh7fff);
    send_item(-16'sh8000);
    send_item(16'sd1);
    send_item(-16'sd1);
    send_item(16'sd0);
    // step 1.0: every point lands on the sample, full negative clips
    write_step(STEP_ONE);
    send_item(-16'sh8000);
    send_item(16'sh7fff);
    send_item(-16'sh8000);
    // step 0.5: midpoints, rounding ties
    write_step(STEP_HALF);
    send_item(16'sh7fff);
    send_item(-16'sh8000);
    send_item(16'sd3);
    send_item(16'sd0);
    send_item(-16'sd3);
    // zero step: capped outputs, dropped positions
    write_step('0);
    send_item(16'sh1234);
    send_item(-16'sh4321);
    // largest step: most items give nothing
    write_step(STEP_MAX);
    send_item(16'sh7fff);
    send_item(16'sd5);
    send_item(-16'sd5);
    send_item(16'sh0100);
    // lowest nominal step, then the same value again to clear state
    write_step(STEP_MIN);
    send_item(-16'sh7fff);
    send_item(16'sh7fff);
    write_step(STEP_MIN);
    send_item(16'sh4000);

    // random phases, each with its own step
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        step_v = STEP_W'($urandom_range(32'd131072, 32'd6291456));
      end else if (sel < 85) begin
        step_v = STEP_W'($urandom_range(0, 131071));
      end else begin
        step_v = STEP_W'($urandom_range(0, 32'hffffff));
      end
      write_step(step_v);
      // first phase: long receiver hold-off while samples keep coming; second: no idling; later: random idling
      if (phase == 0) begin
        tx_idle_en = 1'b0;
        hold_req   = hold_req + 1;
      end else if (phase == 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else begin
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
      end
      phase_len = $urandom_range(10, 30);
      repeat (phase_len) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
          s = SAMPLE_W'($urandom());
        end else begin
          case ($urandom_range(0, 4))
            0: s = 16'sh7fff;
            1: s = -16'sh8000;
            2: s = 16'sd0;
            3: s = -16'sd1;
            default: s = 16'sd1;
          endcase
        end
        send_item(s);
        sent++;
      end
      phase++;
    end

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    drain(END_CYCLES);
    if (fail_count == 0) begin
      $display("linear_interp_resampler_core: match");
    end else begin
      $display("linear_interp_resampler_core: mismatch");
    end
    $finish;
  end

endmodule
